// File: src/hhmm_pkg.sv
// Shared types, address constants and reset image of the handheld memory map.
package hhmm_pkg;

   localparam int ADDR_W          = 16;
   localparam int DATA_W          = 8;
   localparam int MEM_DEPTH       = 65536;
   localparam int COPY_LENGTH_DEF = 160;
   // Wide enough to count a full 256-byte copy.
   localparam int CNT_W           = 9;

   typedef logic [1:0]        op_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]  count_type;

   localparam op_type OP_READ    = 2'd0;
   localparam op_type OP_CHECKED = 2'd1;
   localparam op_type OP_LOAD    = 2'd2;

   localparam addr_type REG_JOYPAD  = 16'hFF00;
   localparam addr_type REG_DIVIDER = 16'hFF04;
   localparam addr_type REG_STATUS  = 16'hFF41;
   localparam addr_type REG_LINE    = 16'hFF44;
   localparam addr_type REG_DMA     = 16'hFF46;
   localparam addr_type SPRITE_BASE = 16'hFE00;
   localparam addr_type ROM_END     = 16'h8000;
   localparam addr_type WRAM_LO     = 16'hC000;
   localparam addr_type WRAM_HI     = 16'hDE00;
   localparam addr_type ECHO_LO     = 16'hE000;
   localparam addr_type ECHO_HI     = 16'hFE00;
   localparam addr_type ECHO_OFFSET = 16'h2000;

   localparam data_type JOYPAD_MASK = 8'h30;
   localparam data_type STATUS_KEEP = 8'h07;

   // Power-up contents of one byte of the map.
   function automatic data_type reset_value(addr_type a);
      data_type v;
      v = 8'h00;
      case (a)
         16'hFF00: v = 8'h3F;
         16'hFF10: v = 8'h80;
         16'hFF11: v = 8'hBF;
         16'hFF12: v = 8'hF3;
         16'hFF14: v = 8'hBF;
         16'hFF16: v = 8'h3F;
         16'hFF19: v = 8'hBF;
         16'hFF1A: v = 8'hBF;
         16'hFF1B: v = 8'hFF;
         16'hFF1C: v = 8'h9F;
         16'hFF1E: v = 8'hBF;
         16'hFF20: v = 8'hFF;
         16'hFF24: v = 8'h77;
         16'hFF25: v = 8'hF3;
         16'hFF26: v = 8'hF1;
         16'hFF40: v = 8'h91;
         16'hFF41: v = 8'h02;
         16'hFF47: v = 8'hFC;
         16'hFF48: v = 8'hFF;
         16'hFF49: v = 8'hFF;
         default:  v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// File: src/hhmm_if.sv
// Valid/ready channel interfaces for bus requests and read responses.
interface hhmm_req_if;
   logic               valid;
   logic               ready;
   hhmm_pkg::op_type   op;
   hhmm_pkg::addr_type address;
   hhmm_pkg::data_type write_data;

   modport source (output valid, output op, output address, output write_data, input ready);
   modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

interface hhmm_rsp_if;
   logic               valid;
   logic               ready;
   hhmm_pkg::data_type read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

// File: src/hhmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hhmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/handheld_memory_map_with_dma.sv
// Reads, plain and ignored writes go from acceptance through ST_DONE to the output register;
// joypad and status writes pass through ST_MERGE, mirrored work RAM writes through ST_MIRROR;
// a DMA register write runs ST_COPY for COPY_LENGTH bytes, one byte per cycle through the
// single write port of the map RAM, then ST_DMA_REG. One item is in work at a time, so no new
// item is accepted until the last has left ST_DONE; a finished item waits in the output
// register while the next one is accepted. After reset a clearing pass writes the power-up
// image into all 65536 bytes, one per cycle, and no item is accepted until it completes.
module handheld_memory_map_with_dma #(
   parameter int COPY_LENGTH = hhmm_pkg::COPY_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hhmm_req_if.sink   req_chan,
   hhmm_rsp_if.source rsp_chan
);
   import hhmm_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_MERGE   = 3'd2;
   localparam logic [2:0] ST_MIRROR  = 3'd3;
   localparam logic [2:0] ST_COPY    = 3'd4;
   localparam logic [2:0] ST_DMA_REG = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   addr_type   clear_addr_ff, clear_addr_in;
   count_type  count_ff, count_in;
   addr_type   addr_ff, addr_in;
   data_type   wdata_ff, wdata_in;
   logic       sel_read_ff, sel_read_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_data_ff, rsp_data_in;

   logic       ram_we, ram_re;
   addr_type   ram_waddr, ram_raddr;
   data_type   ram_wdata, ram_rdata;

   logic       accept, out_free;
   data_type   checked_val;
   logic       in_wram, in_echo;
   addr_type   copy_src, copy_dst;

   hhmm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign checked_val = (req_chan.address == REG_LINE || req_chan.address == REG_DIVIDER)
                        ? '0 : req_chan.write_data;
   assign in_wram = (req_chan.address >= WRAM_LO) && (req_chan.address < WRAM_HI);
   assign in_echo = (req_chan.address >= ECHO_LO) && (req_chan.address < ECHO_HI);

   // The source page sits in wdata_ff during a copy; the sum wraps to 16 bits.
   assign copy_src   = {wdata_ff, 8'h00} + ADDR_W'(count_ff);
   assign copy_dst   = SPRITE_BASE + ADDR_W'(count_ff);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      sel_read_in   = sel_read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = req_chan.address;
      ram_wdata     = req_chan.write_data;
      ram_re        = 1'b0;
      ram_raddr     = req_chan.address;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we        = 1'b1;
            ram_waddr     = clear_addr_ff;
            ram_wdata     = reset_value(clear_addr_ff);
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               sel_read_in = 1'b0;
               addr_in     = req_chan.address;
               wdata_in    = checked_val;
               state_in    = ST_DONE;
               case (req_chan.op)
                  OP_READ: begin
                     ram_re      = 1'b1;
                     sel_read_in = 1'b1;
                  end
                  OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  OP_CHECKED: begin
                     if (req_chan.address == REG_DMA) begin
                        // Fetch the first source byte; the copy then streams one byte a cycle.
                        wdata_in  = req_chan.write_data;
                        count_in  = '0;
                        ram_re    = 1'b1;
                        ram_raddr = {req_chan.write_data, 8'h00};
                        state_in  = ST_COPY;
                     end else if (req_chan.address == REG_JOYPAD ||
                                  req_chan.address == REG_STATUS) begin
                        ram_re   = 1'b1;
                        state_in = ST_MERGE;
                     end else if (req_chan.address >= ROM_END) begin
                        ram_we    = 1'b1;
                        ram_wdata = checked_val;
                        if (in_wram) begin
                           addr_in  = req_chan.address + ECHO_OFFSET;
                           state_in = ST_MIRROR;
                        end else if (in_echo) begin
                           addr_in  = req_chan.address - ECHO_OFFSET;
                           state_in = ST_MIRROR;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            if (addr_ff == REG_JOYPAD) begin
               ram_wdata = (wdata_ff & JOYPAD_MASK) | (ram_rdata & ~JOYPAD_MASK);
            end else begin
               ram_wdata = (wdata_ff & ~STATUS_KEEP) | (ram_rdata & STATUS_KEEP);
            end
            state_in = ST_DONE;
         end
         ST_MIRROR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = wdata_ff;
            state_in  = ST_DONE;
         end
         ST_COPY: begin
            // The next source read can never hit the byte written this cycle, since both pages start
            // on a page boundary and the read offset runs one byte ahead of the write offset.
            ram_we    = 1'b1;
            ram_waddr = copy_dst;
            ram_wdata = ram_rdata;
            count_in  = count_ff + 1'b1;
            if (count_ff == CNT_W'(COPY_LENGTH - 1)) begin
               state_in = ST_DMA_REG;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = copy_src + 1'b1;
            end
         end
         ST_DMA_REG: begin
            ram_we    = 1'b1;
            ram_waddr = REG_DMA;
            ram_wdata = wdata_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sel_read_ff ? ram_rdata : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      sel_read_ff <= sel_read_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
endmodule

// File: src/hhmm_checker.sv
// Port-level checks on the memory map, bound to the top level.
module hhmm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input hhmm_pkg::data_type rsp_read_data
);
   import hhmm_pkg::*;

   // The clearing pass keeps the request side closed right after reset.
   assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   // Accepting an item closes the request side, so the next item cannot enter back to back.
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted back to back");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=> $stable(rsp_read_data))
      else $error("response data changed while stalled");
endmodule

bind handheld_memory_map_with_dma hhmm_checker u_hhmm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data)
);

// File: bench/hhmm_map_check.sv
// Watches the request and response channels, predicts read data and compares it.
module hhmm_map_check #(
   parameter int COPY_LENGTH = hhmm_pkg::COPY_LENGTH_DEF
) (
   input  logic clock,
   input  logic reset,
   hhmm_req_if  req_mon,
   hhmm_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count
);
   import hhmm_pkg::*;

   localparam addr_type IO_DEFAULT_ADDR [20] = '{
      16'hFF00, 16'hFF10, 16'hFF11, 16'hFF12, 16'hFF14, 16'hFF16, 16'hFF19, 16'hFF1A,
      16'hFF1B, 16'hFF1C, 16'hFF1E, 16'hFF20, 16'hFF24, 16'hFF25, 16'hFF26, 16'hFF40,
      16'hFF41, 16'hFF47, 16'hFF48, 16'hFF49
   };
   localparam data_type IO_DEFAULT_VAL [20] = '{
      8'h3F, 8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F, 8'hBF, 8'hBF,
      8'hFF, 8'h9F, 8'hBF, 8'hFF, 8'h77, 8'hF3, 8'hF1, 8'h91,
      8'h02, 8'hFC, 8'hFF, 8'hFF
   };

   data_type   map_image [0:MEM_DEPTH-1];
   logic [7:0] sprite_copy_count;
   data_type   read_bytes_due [$];

   // Applies one CPU write with the I/O register rules, the work RAM mirror and
   // the sprite-table copy.
   task automatic model_checked_write(addr_type a, data_type v);
      addr_type src;
      data_type stored;
      stored = v;
      if (a == REG_DMA) begin
         // Copies in rising order, as the block does.
         for (int n = 0; n < COPY_LENGTH; n++) begin
            src = {v, 8'h00} + addr_type'(n);
            map_image[SPRITE_BASE + addr_type'(n)] = map_image[src];
         end
         sprite_copy_count = 8'(COPY_LENGTH);
      end else if (a == REG_JOYPAD) begin
         stored = (v & JOYPAD_MASK) | (map_image[REG_JOYPAD] & ~JOYPAD_MASK);
      end else if (a == REG_STATUS) begin
         stored = (v & ~STATUS_KEEP) | (map_image[REG_STATUS] & STATUS_KEEP);
      end else if (a == REG_LINE || a == REG_DIVIDER) begin
         stored = '0;
      end
      if (a >= WRAM_LO && a < WRAM_HI) map_image[a + ECHO_OFFSET] = stored;
      if (a >= ECHO_LO && a < ECHO_HI) map_image[a - ECHO_OFFSET] = stored;
      if (a >= ROM_END) map_image[a] = stored;
   endtask

   task automatic note_error(string what, data_type want, data_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) map_image[i] = '0;
         for (int k = 0; k < 20; k++) map_image[IO_DEFAULT_ADDR[k]] = IO_DEFAULT_VAL[k];
         sprite_copy_count = '0;
         read_bytes_due.delete();
         error_count = 0;
      end else begin
         // A response always belongs to an older item, so it is checked first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (read_bytes_due.size() == 0)
               note_error("response with no item outstanding", 8'h00, rsp_mon.read_data);
            else if (rsp_mon.read_data !== read_bytes_due[0])
               note_error("read_data mismatch", read_bytes_due.pop_front(), rsp_mon.read_data);
            else
               void'(read_bytes_due.pop_front());
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.op)
               OP_READ: begin
                  read_bytes_due.push_back(map_image[req_mon.address]);
               end
               OP_CHECKED: begin
                  model_checked_write(req_mon.address, req_mon.write_data);
                  read_bytes_due.push_back(8'h00);
               end
               OP_LOAD: begin
                  map_image[req_mon.address] = req_mon.write_data;
                  read_bytes_due.push_back(8'h00);
               end
               default: begin
                  read_bytes_due.push_back(8'h00);
               end
            endcase
         end
      end
      pending_count <= read_bytes_due.size();
   end

endmodule

// File: bench/tb.sv
// Top of the memory map testbench: clock, reset, bus traffic and the verdict.
module tb;
   import hhmm_pkg::*;

   // Operation code the block does not use; it must change nothing.
   localparam op_type OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   int   hold_request = 0;
   int   hold_left = 0;

   hhmm_req_if req_chan ();
   hhmm_rsp_if rsp_chan ();

   handheld_memory_map_with_dma i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hhmm_map_check i_map_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #6000000;
      $display("TB_ERROR");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = 300;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_item(op_type op, addr_type a, data_type d);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.address    <= a;
      req_chan.write_data <= d;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_all_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Mostly addresses near region borders and special registers, the rest anywhere.
   function automatic addr_type pick_address();
      addr_type windows [9] = '{16'h0000, 16'h7F80, 16'hBF80, 16'hC000, 16'hDD80,
                                16'hDF80, 16'hFD80, 16'hFE00, 16'hFF00};
      if ($urandom_range(99) < 35) return addr_type'($urandom_range(16'hFFFF));
      return windows[$urandom_range(8)] + addr_type'($urandom_range(255));
   endfunction

   task automatic send_random_item();
      addr_type specials [4] = '{REG_JOYPAD, REG_STATUS, REG_LINE, REG_DIVIDER};
      data_type pages [8] = '{8'h00, 8'h7F, 8'hC0, 8'hDD, 8'hE0, 8'hFD, 8'hFE, 8'hFF};
      int       pick;
      data_type d;
      pick = $urandom_range(99);
      d = data_type'($urandom_range(255));
      if (pick < 2) begin
         send_item(OP_UNUSED, pick_address(), d);
      end else if (pick < 45) begin
         send_item(OP_READ, pick_address(), d);
      end else if (pick < 70) begin
         pick = $urandom_range(99);
         if (pick < 3)
            send_item(OP_CHECKED, REG_DMA,
                      ($urandom_range(1) != 0) ? pages[$urandom_range(7)] : d);
         else if (pick < 13)
            send_item(OP_CHECKED, specials[$urandom_range(3)], d);
         else
            send_item(OP_CHECKED, pick_address(), d);
      end else begin
         send_item(OP_LOAD, pick_address(), d);
      end
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_READ;
      req_chan.address    <= '0;
      req_chan.write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset image, ROM protection, mirrors, I/O rules and the sprite copy.
      send_item(OP_READ,    16'hFF00, 8'h00);
      send_item(OP_READ,    16'hFF41, 8'hFF);
      send_item(OP_READ,    16'h0000, 8'h00);
      send_item(OP_READ,    16'hFFFF, 8'h00);
      send_item(OP_CHECKED, 16'h1234, 8'hAA);
      send_item(OP_READ,    16'h1234, 8'h00);
      send_item(OP_LOAD,    16'h7FFF, 8'hFF);
      send_item(OP_READ,    16'h7FFF, 8'h00);
      send_item(OP_CHECKED, 16'hC000, 8'h5A);
      send_item(OP_READ,    16'hE000, 8'h00);
      send_item(OP_CHECKED, 16'hFDFF, 8'hA5);
      send_item(OP_READ,    16'hDDFF, 8'h00);
      send_item(OP_CHECKED, 16'hDE00, 8'h77);
      send_item(OP_READ,    16'hFE00, 8'h00);
      send_item(OP_CHECKED, REG_JOYPAD, 8'h00);
      send_item(OP_READ,    REG_JOYPAD, 8'h00);
      send_item(OP_CHECKED, REG_STATUS, 8'hFF);
      send_item(OP_READ,    REG_STATUS, 8'h00);
      send_item(OP_CHECKED, REG_LINE, 8'hFF);
      send_item(OP_CHECKED, REG_DIVIDER, 8'hFF);
      send_item(OP_LOAD,    16'hC005, 8'h81);
      send_item(OP_CHECKED, REG_DMA, 8'hC0);
      send_item(OP_READ,    16'hFE05, 8'h00);
      send_item(OP_READ,    REG_DMA, 8'h00);
      send_item(OP_UNUSED,  16'hFFFF, 8'hFF);
      send_item(OP_CHECKED, REG_DMA, 8'hFF);
      wait_all_responses();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         for (int i = 0; i < 306; i++) begin
            // The response side holds off while items keep coming, so the block backs up.
            if (phase == 0 && i == 100) hold_request = 1;
            if (phase == 1 && i == 150) wait_all_responses();
            send_random_item();
         end
         wait_all_responses();
      end

      repeat (COPY_LENGTH_DEF + 8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
